// ===== rtl/assert_macros.svh =====
// assertion macros of the identifier set table, included by its top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("%m: invariant violated");

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: implication violated");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication violated");

`else

`define ASSERT_ALWAYS(label, clk, rstn, prop)
`define ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/idst_pkg.sv =====
// shared types and constants of the identifier set table
package idst_pkg;

    localparam int ID_W        = 32;
    localparam int POS_W       = 8;
    localparam int COUNT_OUT_W = 9;
    localparam int CMD_W       = 2;

    // default number of slots
    localparam int CAPACITY_DEF = 16;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

    // status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // command word
    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [ID_W-1:0]  id_value;
        logic [POS_W-1:0] position;
    } in_word_t;

    // result word
    typedef struct packed {
        logic                   status;
        logic                   found;
        logic [ID_W-1:0]        id_out;
        logic [COUNT_OUT_W-1:0] count_out;
    } out_word_t;

endpackage

// ===== rtl/idst_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
module idst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/id_set_table.sv =====
// top level of the identifier set table: command sequencer around the entry ram
//
//  channel | ports                    | direction | word
//  --------+--------------------------+-----------+-----------
//  command | s_valid s_ready s_word   | in        | in_word_t
//  result  | m_valid m_ready m_word   | out       | out_word_t
//
// add and a read-at miss go from acceptance straight to the done state, a read-at
// hit through the read state; search and delete scan one used slot per cycle, and
// a delete hit then passes through the swap state (an empty set goes straight to done)
// aresetn clears the count, the sequencer and the output valid; the entry ram needs no clearing
// the next command is taken in the cycle after the result is loaded, even while
// it waits in the output register; a finished result waits for that register
module id_set_table
    import idst_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_word,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_word
);

`include "assert_macros.svh"

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_READ = 5'b00100,
        S_SWAP = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CMD_W-1:0] cmd_reg, cmd_next;
    logic [ID_W-1:0]  key_reg, key_next;
    logic [AW-1:0]    cmp_idx_reg, cmp_idx_next;
    logic [AW-1:0]    slot_reg, slot_next;
    out_word_t        res_reg, res_next;
    out_word_t        out_reg;
    logic             m_valid_reg;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [ID_W-1:0]  ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [ID_W-1:0]  ram_rdata;

    logic             accept;
    logic             out_free;
    logic             res_load;
    logic [CW-1:0]    last_cnt;
    logic             scan_last;
    logic             pos_hit;

    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign res_load  = (state_reg == S_DONE) && out_free;
    assign last_cnt  = count_reg - CW'(1);
    assign scan_last = (CW'(cmp_idx_reg) == last_cnt);
    assign pos_hit   = ({1'b0, s_word.position} < COUNT_OUT_W'(count_reg));

    // entry store
    idst_ram #(
        .WIDTH (ID_W),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_entries (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // command sequencer
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        cmd_next     = cmd_reg;
        key_next     = key_reg;
        cmp_idx_next = cmp_idx_reg;
        slot_next    = slot_reg;
        res_next     = res_reg;
        ram_we       = 1'b0;
        ram_waddr    = AW'(count_reg);
        ram_wdata    = s_word.id_value;
        ram_re       = 1'b0;
        ram_raddr    = '0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd_next = s_word.command;
                    key_next = s_word.id_value;
                    res_next = '0;
                    case (s_word.command)
                        CMD_ADD: begin
                            if (count_reg == CW'(CAPACITY)) begin
                                res_next.status    = STATUS_ERR;
                                res_next.count_out = COUNT_OUT_W'(count_reg);
                            end else begin
                                ram_we             = 1'b1;
                                count_next         = count_reg + CW'(1);
                                res_next.count_out = COUNT_OUT_W'(count_reg + CW'(1));
                            end
                            state_next = S_DONE;
                        end
                        CMD_READ: begin
                            res_next.count_out = COUNT_OUT_W'(count_reg);
                            if (pos_hit) begin
                                ram_re     = 1'b1;
                                ram_raddr  = AW'(s_word.position);
                                state_next = S_READ;
                            end else begin
                                state_next = S_DONE;
                            end
                        end
                        default: begin
                            // search and delete share the scan
                            res_next.count_out = COUNT_OUT_W'(count_reg);
                            if (count_reg == '0) begin
                                if (s_word.command == CMD_DELETE) begin
                                    res_next.status = STATUS_ERR;
                                end
                                state_next = S_DONE;
                            end else begin
                                ram_re       = 1'b1;
                                ram_raddr    = '0;
                                cmp_idx_next = '0;
                                state_next   = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // ram_rdata holds the entry at cmp_idx_reg
                if (ram_rdata == key_reg) begin
                    if (cmd_reg == CMD_DELETE) begin
                        slot_next  = cmp_idx_reg;
                        ram_re     = 1'b1;
                        ram_raddr  = AW'(last_cnt);
                        state_next = S_SWAP;
                    end else begin
                        res_next.found  = 1'b1;
                        res_next.id_out = key_reg;
                        state_next      = S_DONE;
                    end
                end else if (scan_last) begin
                    if (cmd_reg == CMD_DELETE) begin
                        res_next.status = STATUS_ERR;
                    end
                    state_next = S_DONE;
                end else begin
                    ram_re       = 1'b1;
                    ram_raddr    = cmp_idx_reg + AW'(1);
                    cmp_idx_next = cmp_idx_reg + AW'(1);
                end
            end
            S_READ: begin
                res_next.found  = 1'b1;
                res_next.id_out = ram_rdata;
                state_next      = S_DONE;
            end
            S_SWAP: begin
                // move the last entry into the freed slot
                ram_we             = 1'b1;
                ram_waddr          = slot_reg;
                ram_wdata          = ram_rdata;
                count_next         = last_cnt;
                res_next.count_out = COUNT_OUT_W'(last_cnt);
                state_next         = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        key_reg     <= key_next;
        cmp_idx_reg <= cmp_idx_next;
        slot_reg    <= slot_next;
        res_reg     <= res_next;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            out_reg <= res_reg;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_word  = out_reg;

    // checks
    `ASSERT_ALWAYS(a_count_in_range, aclk, aresetn, count_reg <= CW'(CAPACITY))
    `ASSERT_IMPLY(a_write_states, aclk, aresetn, ram_we, state_reg == S_IDLE || state_reg == S_SWAP)
    `ASSERT_IMPLY(a_scan_in_range, aclk, aresetn, state_reg == S_SCAN, CW'(cmp_idx_reg) < count_reg)
    `ASSERT_NEXT(a_result_from_done, aclk, aresetn, res_load, m_valid_reg && state_reg == S_IDLE)

endmodule
